// ----- rtl/sste_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes for the shadow scan time estimator.
// No dependencies; the interfaces, the top and the checker import this package.
package sste_pkg;

    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;

    localparam int ACTION_W = 2;
    localparam int PIX_W    = 8;
    localparam int FRAME_W  = 8;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;

    localparam logic [PIX_W-1:0] THRESH_RESET = 8'd70;
    localparam logic [PIX_W-1:0] PIX_FULL     = 8'd255;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACCUM    = 2'd0,
        ACT_CLASSIFY = 2'd1,
        ACT_READ     = 2'd2
    } t_action;

    typedef struct packed {
        logic [FRAME_W-1:0] tm;
        logic [PIX_W-1:0]   mn;
        logic [PIX_W-1:0]   mx;
    } t_pix_word;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } t_col_word;

    typedef struct packed {
        logic [PIX_W-1:0]   shadowless_value;
        logic [PIX_W-1:0]   shadowed_value;
        logic [PIX_W-1:0]   difference;
        logic               shadow_mask;
        logic [FRAME_W-1:0] shadow_time;
        logic               time_written;
    } t_result;

endpackage

// ----- rtl/sste_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input, result output, threshold write.
// Depends on sste_pkg for field widths.
interface sste_pix_if;
    import sste_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PIX_W-1:0]    pixel_value;
    logic [FRAME_W-1:0]  frame_index;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;
    modport source (output valid, action, pixel_value, frame_index, column, row, input ready);
    modport sink   (input valid, action, pixel_value, frame_index, column, row, output ready);
endinterface

interface sste_res_if;
    import sste_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   shadowless_value;
    logic [PIX_W-1:0]   shadowed_value;
    logic [PIX_W-1:0]   difference;
    logic               shadow_mask;
    logic [FRAME_W-1:0] shadow_time;
    logic               time_written;
    modport source (output valid, shadowless_value, shadowed_value, difference,
                    shadow_mask, shadow_time, time_written, input ready);
    modport sink   (input valid, shadowless_value, shadowed_value, difference,
                    shadow_mask, shadow_time, time_written, output ready);
endinterface

interface sste_cfg_if;
    import sste_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mask_threshold;
    modport source (output valid, mask_threshold, input ready);
    modport sink   (input valid, mask_threshold, output ready);
endinterface

// ----- rtl/sste_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/shadow_scan_time_estimator_top.sv -----
`timescale 1ns / 1ps
// Channel    | Dir | Beat contents
// i_pix      | in  | action, pixel_value, frame_index, column, row
// o_res      | out | shadowless/shadowed value, difference, mask, shadow_time, time_written
// i_cfg      | in  | mask_threshold (always ready)
// One pixel per cycle sustained while o_res is ready; each beat passes the read stage, then the output register.
// Per-pixel state sits in one RAM (max, min, time); column state in a second RAM.
// Read at accept, modify and write back when the read stage fires; a same-address follower is forwarded.
// After reset a clear pass over all IMAGE_WIDTH*IMAGE_HEIGHT pixel addresses holds i_pix.ready low.
// A stalled o_res holds the output register, then the read stage, then i_pix.ready.
// Depends on sste_pkg, sste_if and sste_ram.
module shadow_scan_time_estimator_top #(
    parameter int IMAGE_WIDTH  = sste_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = sste_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sste_pix_if.sink  i_pix,
    sste_res_if.source o_res,
    sste_cfg_if.sink  i_cfg
);
    import sste_pkg::*;

    localparam int PIXEL_COUNT = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int PIX_AW      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int COL_AW      = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
    localparam int EXT_W       = 25;

    logic [PIX_W-1:0]  r_thresh;
    logic              r_clearing;
    logic [PIX_AW-1:0] r_clr_addr;

    logic              r_s1_valid;
    logic [ACTION_W-1:0] r_s1_action;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [FRAME_W-1:0] r_s1_frame;
    logic [PIX_AW-1:0] r_s1_addr;
    logic [COL_AW-1:0] r_s1_col;
    logic              r_s1_in_range;
    logic              r_s1_pfwd;
    t_pix_word         r_s1_pfwd_data;
    logic              r_s1_cfwd;
    t_col_word         r_s1_cfwd_data;

    logic              r_out_valid;
    t_result           r_out;

    logic [EXT_W-1:0]  col_ext;
    logic [EXT_W-1:0]  row_ext;
    logic [EXT_W-1:0]  addr_full;
    logic [EXT_W-1:0]  clr_ext;
    logic [PIX_AW-1:0] in_addr;
    logic [COL_AW-1:0] in_col;
    logic              in_range;
    logic              accept;
    logic              s1_fire;

    t_pix_word         pix_rdata;
    t_col_word         col_rdata;
    t_pix_word         cur_pix;
    t_col_word         cur_col;
    t_pix_word         n_pix_word;
    t_col_word         n_col_word;
    t_result           n_result;
    logic              pix_we;
    logic              col_we;
    logic [PIX_W-1:0]  diff;
    logic              mask;
    logic              wr_time;

    logic              ram_pix_we;
    logic [PIX_AW-1:0] ram_pix_waddr;
    t_pix_word         ram_pix_wdata;
    logic              ram_col_we;
    logic [COL_AW-1:0] ram_col_waddr;
    t_col_word         ram_col_wdata;

    // threshold register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg.valid) begin
            r_thresh <= i_cfg.mask_threshold;
        end
    end

    // clear pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == PIX_AW'(PIXEL_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // input decode
    assign col_ext   = EXT_W'(i_pix.column);
    assign row_ext   = EXT_W'(i_pix.row);
    assign in_range  = (col_ext < EXT_W'(IMAGE_WIDTH)) && (row_ext < EXT_W'(IMAGE_HEIGHT));
    assign addr_full = row_ext * EXT_W'(IMAGE_WIDTH) + col_ext;
    assign in_addr   = addr_full[PIX_AW-1:0];
    assign in_col    = col_ext[COL_AW-1:0];

    assign s1_fire     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_clearing && (!r_s1_valid || s1_fire);
    assign accept      = i_pix.valid && i_pix.ready;

    // read-modify stage
    assign cur_pix = r_s1_pfwd ? r_s1_pfwd_data : pix_rdata;
    assign cur_col = r_s1_cfwd ? r_s1_cfwd_data : col_rdata;

    always_comb begin
        n_pix_word = cur_pix;
        n_col_word = '{valid: 1'b1, frame: r_s1_frame};
        pix_we     = 1'b0;
        col_we     = 1'b0;
        diff       = '0;
        mask       = 1'b0;
        wr_time    = 1'b0;
        if (r_s1_in_range) begin
            case (r_s1_action)
                ACT_ACCUM: begin
                    if (r_s1_pix > cur_pix.mx) begin
                        n_pix_word.mx = r_s1_pix;
                    end
                    if (r_s1_pix < cur_pix.mn) begin
                        n_pix_word.mn = r_s1_pix;
                    end
                    pix_we = 1'b1;
                end
                ACT_CLASSIFY: begin
                    diff = (cur_pix.mx >= r_s1_pix) ? (cur_pix.mx - r_s1_pix)
                                                    : (r_s1_pix - cur_pix.mx);
                    mask = diff > r_thresh;
                    wr_time = mask && !(cur_col.valid && (cur_col.frame == r_s1_frame));
                    if (wr_time) begin
                        n_pix_word.tm = r_s1_frame;
                        pix_we        = 1'b1;
                        col_we        = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_s1_in_range) begin
            n_result = '{shadowless_value: n_pix_word.mx, shadowed_value: n_pix_word.mn,
                         difference: diff, shadow_mask: mask,
                         shadow_time: n_pix_word.tm, time_written: wr_time};
        end else begin
            n_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action    <= i_pix.action;
            r_s1_pix       <= i_pix.pixel_value;
            r_s1_frame     <= i_pix.frame_index;
            r_s1_addr      <= in_addr;
            r_s1_col       <= in_col;
            r_s1_in_range  <= in_range;
            r_s1_pfwd      <= s1_fire && pix_we && (r_s1_addr == in_addr);
            r_s1_pfwd_data <= n_pix_word;
            r_s1_cfwd      <= s1_fire && col_we && (r_s1_col == in_col);
            r_s1_cfwd_data <= n_col_word;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_result;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.shadowless_value = r_out.shadowless_value;
    assign o_res.shadowed_value   = r_out.shadowed_value;
    assign o_res.difference       = r_out.difference;
    assign o_res.shadow_mask      = r_out.shadow_mask;
    assign o_res.shadow_time      = r_out.shadow_time;
    assign o_res.time_written     = r_out.time_written;

    // memory write ports
    assign clr_ext       = EXT_W'(r_clr_addr);
    assign ram_pix_we    = r_clearing || (s1_fire && pix_we);
    assign ram_pix_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign ram_pix_wdata = r_clearing ? t_pix_word'{tm: '0, mn: PIX_FULL, mx: '0} : n_pix_word;
    assign ram_col_we    = r_clearing ? (clr_ext < EXT_W'(IMAGE_WIDTH)) : (s1_fire && col_we);
    assign ram_col_waddr = r_clearing ? clr_ext[COL_AW-1:0] : r_s1_col;
    assign ram_col_wdata = r_clearing ? t_col_word'('0) : n_col_word;

    sste_ram #(
        .WIDTH ($bits(t_pix_word)),
        .DEPTH (PIXEL_COUNT)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (ram_pix_we),
        .i_waddr (ram_pix_waddr),
        .i_wdata (ram_pix_wdata),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (pix_rdata)
    );

    sste_ram #(
        .WIDTH ($bits(t_col_word)),
        .DEPTH (IMAGE_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (ram_col_we),
        .i_waddr (ram_col_waddr),
        .i_wdata (ram_col_wdata),
        .i_re    (accept),
        .i_raddr (in_col),
        .o_rdata (col_rdata)
    );
endmodule

// ----- rtl/sste_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the shadow scan time estimator and their bind.
// Depends on sste_pkg and shadow_scan_time_estimator_top.
module sste_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_pix_valid,
    input logic                       i_pix_ready,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [sste_pkg::PIX_W-1:0] i_res_shadowless_value,
    input logic [sste_pkg::PIX_W-1:0] i_res_difference,
    input logic                       i_res_shadow_mask,
    input logic [sste_pkg::FRAME_W-1:0] i_res_shadow_time,
    input logic                       i_res_time_written
);
    import sste_pkg::*;

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_ready)
        else $error("pixel input ready during clear pass");

    a_written_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_time_written) |-> (i_res_shadow_mask && (i_res_difference != '0)))
        else $error("time store written without a mask");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_pix_valid && i_pix_ready, 2))
        else $error("result beat without matching input beat");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_shadowless_value)
            && $stable(i_res_shadow_time) && $stable(i_res_difference)))
        else $error("stalled result beat changed");
endmodule

bind shadow_scan_time_estimator_top sste_checker u_sste_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_pix_valid            (i_pix.valid),
    .i_pix_ready            (i_pix.ready),
    .i_res_valid            (o_res.valid),
    .i_res_ready            (o_res.ready),
    .i_res_shadowless_value (o_res.shadowless_value),
    .i_res_difference       (o_res.difference),
    .i_res_shadow_mask      (o_res.shadow_mask),
    .i_res_shadow_time      (o_res.shadow_time),
    .i_res_time_written     (o_res.time_written)
);
